>>> sv/poly_voice_allocator_defines.svh
// Assertion macros shared by the voice allocator RTL.
`ifndef POLY_VOICE_ALLOCATOR_DEFINES_SVH
`define POLY_VOICE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define PVA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`define PVA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define PVA_ASSERT_IMP(lbl, ante, cons, msg)
`define PVA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/pva_pkg.sv
// Shared constants, codes and types of the voice allocator.
package pva_pkg;

  localparam int MaxVoices     = 16;
  localparam int VoiceCountRst = 16;
  localparam int IdxW          = (MaxVoices > 1) ? $clog2(MaxVoices) : 1;
  localparam int CountW        = $clog2(MaxVoices + 1);
  localparam int ListAddrW     = IdxW + 1;
  localparam int VoiceW        = 4;
  localparam int NoteW         = 7;
  localparam int VelW          = 7;
  localparam int CfgW          = 5;
  localparam int CfgIdxW       = 1;
  localparam int PolicyW       = 2;

  localparam logic [CountW-1:0] FreeCountRst =
    CountW'((VoiceCountRst > MaxVoices) ? MaxVoices : VoiceCountRst);

  typedef enum logic [0:0] {
    ListActive = 1'b0,
    ListFree   = 1'b1
  } pva_list_e;

  typedef enum logic [0:0] {
    ModeOn  = 1'b0,
    ModeOff = 1'b1
  } pva_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgVoiceCount  = 1'b0,
    CfgStealPolicy = 1'b1
  } pva_cfg_e;

  typedef enum logic [PolicyW-1:0] {
    PolicyNone   = 2'd0,
    PolicyOldest = 2'd1,
    PolicyLowest = 2'd2
  } pva_policy_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StFetch,
    StShift,
    StTail
  } pva_state_e;

  // Access request from the sequencer to the list and note memories.
  typedef struct packed {
    logic                 list_re;
    logic [ListAddrW-1:0] list_raddr;
    logic                 list_we;
    logic [ListAddrW-1:0] list_waddr;
    logic [IdxW-1:0]      list_wdata;
    logic                 note_re;
    logic [IdxW-1:0]      note_raddr;
    logic                 note_we;
    logic [IdxW-1:0]      note_waddr;
    logic [NoteW-1:0]     note_wdata;
    logic                 clear;
  } pva_mem_req_t;

endpackage

>>> sv/pva_in_if.sv
// Input event channel: note-on and note-off transactions.
interface pva_in_if;
  import pva_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [NoteW-1:0] note;
  logic [VelW-1:0]  velocity;

  modport source (output valid, output mode, output note, output velocity, input ready);
  modport sink   (input valid, input mode, input note, input velocity, output ready);
endinterface

>>> sv/pva_out_if.sv
// Output channel: voice start and release transactions.
interface pva_out_if;
  import pva_pkg::*;

  logic              valid;
  logic              ready;
  logic [VoiceW-1:0] voice;
  logic              gate;
  logic [NoteW-1:0]  note_out;
  logic [VelW-1:0]   velocity_out;

  modport source (output valid, output voice, output gate, output note_out,
                  output velocity_out, input ready);
  modport sink   (input valid, input voice, input gate, input note_out,
                  input velocity_out, output ready);
endinterface

>>> sv/pva_store.sv
// List memory (active and free lists) and per-voice note memory.
`include "poly_voice_allocator_defines.svh"

module pva_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pva_pkg::pva_mem_req_t     req_i,
  output logic [pva_pkg::IdxW-1:0]  list_rdata_o,
  output logic [pva_pkg::NoteW-1:0] note_rdata_o
);
  import pva_pkg::*;

  logic [IdxW-1:0]      list_mem [2*MaxVoices];
  logic [NoteW-1:0]     note_mem [MaxVoices];
  logic [MaxVoices-1:0] free_vld_q;
  logic [MaxVoices-1:0] note_vld_q;

  logic [IdxW-1:0]  list_rdata_q;
  logic [IdxW-1:0]  list_rpos_q;
  logic             list_rinv_q;
  logic [NoteW-1:0] note_rdata_q;
  logic             note_rinv_q;

  logic wr_free;
  logic rd_free;

  assign wr_free = (pva_list_e'(req_i.list_waddr[ListAddrW-1]) == ListFree);
  assign rd_free = (pva_list_e'(req_i.list_raddr[ListAddrW-1]) == ListFree);

  // Free-list entries and notes read as their reset value until written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_vld_q <= '0;
      note_vld_q <= '0;
    end else if (req_i.clear) begin
      free_vld_q <= '0;
      note_vld_q <= '0;
    end else begin
      if (req_i.list_we && wr_free) begin
        free_vld_q[req_i.list_waddr[IdxW-1:0]] <= 1'b1;
      end
      if (req_i.note_we) begin
        note_vld_q[req_i.note_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.list_we) begin
      list_mem[req_i.list_waddr] <= req_i.list_wdata;
    end
    if (req_i.list_re) begin
      list_rdata_q <= list_mem[req_i.list_raddr];
      list_rpos_q  <= req_i.list_raddr[IdxW-1:0];
      list_rinv_q  <= rd_free && !free_vld_q[req_i.list_raddr[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.note_we) begin
      note_mem[req_i.note_waddr] <= req_i.note_wdata;
    end
    if (req_i.note_re) begin
      note_rdata_q <= note_mem[req_i.note_raddr];
      note_rinv_q  <= !note_vld_q[req_i.note_raddr];
    end
  end

  assign list_rdata_o = list_rinv_q ? list_rpos_q : list_rdata_q;
  assign note_rdata_o = note_rinv_q ? '0 : note_rdata_q;

  `PVA_ASSERT_IMP(a_list_no_rw_same, req_i.list_we && req_i.list_re, req_i.list_waddr != req_i.list_raddr, "list memory read and write hit the same entry")
  `PVA_ASSERT_IMP(a_note_no_rw_same, req_i.note_we && req_i.note_re, req_i.note_waddr != req_i.note_raddr, "note memory read and write hit the same entry")
  `PVA_ASSERT_IMP(a_list_waddr_known, req_i.list_we, !$isunknown(req_i.list_waddr), "list memory write address is unknown")

endmodule

>>> sv/poly_voice_allocator.sv
// Polyphonic voice allocator top level: event sequencer over the list and note memories.
// Sequence: a note-on from the free list fetches the free head and shifts the free list; an
// oldest steal fetches the active head and shifts the active list; a lowest steal or note-off
// first walks the active list, then shifts the list one entry per cycle.
// Throughput: one event at a time; the next is accepted once the sequencer is back in idle.
// Reset: asynchronous, active low; 16 voices, no stealing, all voices free, notes cleared.
`include "poly_voice_allocator_defines.svh"

module poly_voice_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pva_in_if.sink                      in_ch,
  pva_out_if.source                   out_ch,
  input  logic                        cfg_we_i,
  input  logic [pva_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pva_pkg::CfgW-1:0]    cfg_wdata_i
);
  import pva_pkg::*;

  // Control state
  pva_state_e           state_q, state_d;
  logic [CountW-1:0]    ac_q, ac_d;         // active list length
  logic [CountW-1:0]    fc_q, fc_d;         // free list length
  logic [PolicyW-1:0]   policy_q, policy_d;
  logic                 pend_q, pend_d;     // list read in flight during fetch/shift
  logic                 cap_v_q, cap_v_d;   // in-flight read returns the moved voice
  logic                 found_q, found_d;
  logic                 s1_vld_q, s1_vld_d; // scan: list read in flight
  logic                 s2_vld_q, s2_vld_d; // scan: note read in flight
  logic                 out_valid_q, out_valid_d;

  // Event payload and work registers
  pva_mode_e            mode_q, mode_d;
  logic [NoteW-1:0]     note_q, note_d;
  logic [VelW-1:0]      vel_q, vel_d;
  pva_list_e            src_q, src_d;       // list the voice is taken from
  logic [IdxW-1:0]      pos_q, pos_d;       // position removed from that list
  logic [CountW-1:0]    len_q, len_d;       // length of that list
  logic [IdxW-1:0]      tail_q, tail_d;     // write position on the target list
  logic [CountW-1:0]    k_q, k_d;           // read pointer of the walk
  logic [IdxW-1:0]      pend_pos_q, pend_pos_d;
  logic [IdxW-1:0]      v_q, v_d;
  logic [NoteW-1:0]     lowest_q, lowest_d;
  logic [IdxW-1:0]      best_q, best_d;
  logic [IdxW-1:0]      s1_pos_q, s1_pos_d;
  logic [IdxW-1:0]      s2_pos_q, s2_pos_d;
  logic [IdxW-1:0]      out_voice_q, out_voice_d;
  logic                 out_gate_q, out_gate_d;
  logic [NoteW-1:0]     out_note_q, out_note_d;
  logic [VelW-1:0]      out_vel_q, out_vel_d;

  pva_mem_req_t         req;
  logic [IdxW-1:0]      list_rdata;
  logic [NoteW-1:0]     note_rdata;

  logic                 in_acc;
  logic                 in_on;
  logic                 is_on;
  pva_list_e            dst_list;
  logic                 rd_issue;
  logic                 hit;
  logic                 tail_go;
  logic [CountW-1:0]    vc_sat;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_on    = (pva_mode_e'(in_ch.mode) == ModeOn);
  assign is_on    = (mode_q == ModeOn);
  assign dst_list = is_on ? ListActive : ListFree;
  assign tail_go  = !out_valid_q || out_ch.ready;
  assign vc_sat   = (int'(cfg_wdata_i) > MaxVoices) ? CountW'(MaxVoices) : CountW'(cfg_wdata_i);

  // Note-off takes the first match; lowest stealing keeps the first strict minimum.
  assign hit = is_on ? (note_rdata < lowest_q) : ((note_rdata == note_q) && !found_q);

  pva_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .list_rdata_o (list_rdata),
    .note_rdata_o (note_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ac_q        <= '0;
      fc_q        <= FreeCountRst;
      policy_q    <= PolicyNone;
      pend_q      <= 1'b0;
      cap_v_q     <= 1'b0;
      found_q     <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ac_q        <= ac_d;
      fc_q        <= fc_d;
      policy_q    <= policy_d;
      pend_q      <= pend_d;
      cap_v_q     <= cap_v_d;
      found_q     <= found_d;
      s1_vld_q    <= s1_vld_d;
      s2_vld_q    <= s2_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    note_q      <= note_d;
    vel_q       <= vel_d;
    src_q       <= src_d;
    pos_q       <= pos_d;
    len_q       <= len_d;
    tail_q      <= tail_d;
    k_q         <= k_d;
    pend_pos_q  <= pend_pos_d;
    v_q         <= v_d;
    lowest_q    <= lowest_d;
    best_q      <= best_d;
    s1_pos_q    <= s1_pos_d;
    s2_pos_q    <= s2_pos_d;
    out_voice_q <= out_voice_d;
    out_gate_q  <= out_gate_d;
    out_note_q  <= out_note_d;
    out_vel_q   <= out_vel_d;
  end

  always_comb begin
    state_d     = state_q;
    ac_d        = ac_q;
    fc_d        = fc_q;
    policy_d    = policy_q;
    pend_d      = 1'b0;
    cap_v_d     = 1'b0;
    found_d     = found_q;
    s1_vld_d    = 1'b0;
    s2_vld_d    = 1'b0;
    out_valid_d = out_valid_q && !out_ch.ready;
    mode_d      = mode_q;
    note_d      = note_q;
    vel_d       = vel_q;
    src_d       = src_q;
    pos_d       = pos_q;
    len_d       = len_q;
    tail_d      = tail_q;
    k_d         = k_q;
    pend_pos_d  = pend_pos_q;
    v_d         = v_q;
    lowest_d    = lowest_q;
    best_d      = best_q;
    s1_pos_d    = s1_pos_q;
    s2_pos_d    = s2_pos_q;
    out_voice_d = out_voice_q;
    out_gate_d  = out_gate_q;
    out_note_d  = out_note_q;
    out_vel_d   = out_vel_q;
    req         = '0;
    rd_issue    = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          mode_d   = pva_mode_e'(in_ch.mode);
          note_d   = in_ch.note;
          vel_d    = in_ch.velocity;
          found_d  = 1'b0;
          lowest_d = in_ch.note;
          k_d      = '0;
          if (!in_on) begin
            state_d = StScan;
          end else if (fc_q != '0) begin
            // Take the free head and append it to the active tail.
            src_d   = ListFree;
            pos_d   = '0;
            len_d   = fc_q;
            tail_d  = IdxW'(ac_q);
            state_d = StFetch;
          end else begin
            case (pva_policy_e'(policy_q))
              PolicyNone: begin
                state_d = StIdle;
              end
              PolicyOldest: begin
                if (ac_q != '0) begin
                  // Rotate the oldest active voice to the tail.
                  src_d   = ListActive;
                  pos_d   = '0;
                  len_d   = ac_q;
                  tail_d  = IdxW'(ac_q - CountW'(1));
                  state_d = StFetch;
                end
              end
              PolicyLowest: begin
                state_d = StScan;
              end
              default: begin
                state_d = StIdle;
              end
            endcase
          end
        end
      end

      StScan: begin
        // Stage 0: read active entry; stage 1: read its note; stage 2: compare.
        rd_issue        = (k_q < ac_q);
        req.list_re     = rd_issue;
        req.list_raddr  = {ListActive, k_q[IdxW-1:0]};
        s1_vld_d        = rd_issue;
        s1_pos_d        = k_q[IdxW-1:0];
        if (rd_issue) begin
          k_d = CountW'(k_q + CountW'(1));
        end
        req.note_re     = s1_vld_q;
        req.note_raddr  = list_rdata;
        s2_vld_d        = s1_vld_q;
        s2_pos_d        = s1_pos_q;
        if (s2_vld_q && hit) begin
          found_d  = 1'b1;
          best_d   = s2_pos_q;
          lowest_d = note_rdata;
        end
        if (!rd_issue && !s1_vld_q && !s2_vld_q) begin
          if (found_q) begin
            src_d   = ListActive;
            pos_d   = best_q;
            len_d   = ac_q;
            tail_d  = is_on ? IdxW'(ac_q - CountW'(1)) : IdxW'(fc_q);
            state_d = StFetch;
          end else begin
            // Drop: nothing to steal or no voice holds the note.
            state_d = StIdle;
          end
        end
      end

      StFetch: begin
        req.list_re    = 1'b1;
        req.list_raddr = {src_q, pos_q};
        pend_d         = 1'b1;
        cap_v_d        = 1'b1;
        pend_pos_d     = pos_q;
        k_d            = CountW'(CountW'(pos_q) + CountW'(1));
        state_d        = StShift;
      end

      StShift: begin
        // Read entry k, write it one place down in the next cycle.
        rd_issue       = (k_q < len_q);
        req.list_re    = rd_issue;
        req.list_raddr = {src_q, k_q[IdxW-1:0]};
        pend_d         = rd_issue;
        pend_pos_d     = k_q[IdxW-1:0];
        if (rd_issue) begin
          k_d = CountW'(k_q + CountW'(1));
        end
        if (pend_q) begin
          if (cap_v_q) begin
            v_d = list_rdata;
          end else begin
            req.list_we    = 1'b1;
            req.list_waddr = {src_q, IdxW'(pend_pos_q - IdxW'(1))};
            req.list_wdata = list_rdata;
          end
        end
        if (!rd_issue && !pend_q) begin
          state_d = StTail;
        end
      end

      StTail: begin
        // Hold until the output register is free.
        if (tail_go) begin
          req.list_we    = 1'b1;
          req.list_waddr = {dst_list, tail_q};
          req.list_wdata = v_q;
          req.note_we    = is_on;
          req.note_waddr = v_q;
          req.note_wdata = note_q;
          if (src_q != dst_list) begin
            if (dst_list == ListActive) begin
              ac_d = CountW'(ac_q + CountW'(1));
              fc_d = CountW'(fc_q - CountW'(1));
            end else begin
              ac_d = CountW'(ac_q - CountW'(1));
              fc_d = CountW'(fc_q + CountW'(1));
            end
          end
          out_valid_d = 1'b1;
          out_voice_d = v_q;
          out_gate_d  = is_on;
          out_note_d  = note_q;
          out_vel_d   = is_on ? vel_q : '0;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // Writing the voice count resets the list lengths and memories to an all-free list.
    if (cfg_we_i) begin
      case (pva_cfg_e'(cfg_idx_i))
        CfgVoiceCount: begin
          ac_d      = '0;
          fc_d      = vc_sat;
          req.clear = 1'b1;
        end
        CfgStealPolicy: begin
          policy_d = cfg_wdata_i[PolicyW-1:0];
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready         = (state_q == StIdle);
  assign out_ch.valid        = out_valid_q;
  assign out_ch.voice        = VoiceW'(out_voice_q);
  assign out_ch.gate         = out_gate_q;
  assign out_ch.note_out     = out_note_q;
  assign out_ch.velocity_out = out_vel_q;

  `PVA_ASSERT_IMP(a_out_from_tail, $rose(out_valid_q), $past(state_q == StTail), "result appeared outside the tail step")
  `PVA_ASSERT_NXT(a_free_head_fetch, in_acc && in_on && (fc_q != '0), (state_q == StFetch) && (src_q == ListFree), "note-on with free voices did not fetch the free head")
  `PVA_ASSERT_NXT(a_off_scans, in_acc && !in_on, state_q == StScan, "note-off did not start an active list walk")

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the polyphonic voice allocator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pva_pkg::*;

  // Unused policy encoding; the block treats it as no stealing.
  localparam logic [PolicyW-1:0] PolicyReserved = 2'd3;

  // The longest event walks the active list and then shifts it.
  localparam int DrainCycles  = 2 * MaxVoices + 16;
  localparam int StallLimit   = 4000;
  localparam int RandomItems  = 1800;
  localparam int MaxReports   = 40;

  // One voice gate transaction, as the output channel carries it.
  typedef struct packed {
    logic [VoiceW-1:0] voice;
    logic              gate;
    logic [NoteW-1:0]  note;
    logic [VelW-1:0]   vel;
  } gate_evt_t;

  // One row of the directed table: either a register write or an input event.
  typedef struct packed {
    logic             is_cfg;
    pva_cfg_e         cfg_sel;
    logic [CfgW-1:0]  cfg_val;
    pva_mode_e        mode;
    logic [NoteW-1:0] note;
    logic [VelW-1:0]  vel;
    logic             by_hand;
    logic             has_res;
    gate_evt_t        res;
  } stim_row_t;

  localparam logic      Cfg     = 1'b1;
  localparam logic      Evt     = 1'b0;
  localparam logic      ByHand  = 1'b1;
  localparam logic      ByModel = 1'b0;
  localparam gate_evt_t NoRes   = '0;

  localparam int NumDirected = 34;

  // Hand-typed rows carry their expected transaction; the others go through the predictor.
  localparam stim_row_t Directed [NumDirected] = '{
    // Reset state: 16 free voices, no stealing. Velocity zero is still a note-on.
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd0,   7'd0,   ByHand, 1'b1, '{4'd0, 1'b1, 7'd0, 7'd0}},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd127, 7'd127, ByHand, 1'b1,
      '{4'd1, 1'b1, 7'd127, 7'd127}},
    // Note-off returns velocity zero whatever came in.
    '{Evt, CfgVoiceCount, 5'd0, ModeOff, 7'd0,   7'd127, ByHand, 1'b1, '{4'd0, 1'b0, 7'd0, 7'd0}},
    // Released voice keeps its old note but is not active: no transaction.
    '{Evt, CfgVoiceCount, 5'd0, ModeOff, 7'd0,   7'd0,   ByHand, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOff, 7'd127, 7'd0,   ByHand, 1'b1,
      '{4'd1, 1'b0, 7'd127, 7'd0}},
    // Single voice: second note-on is dropped without stealing.
    '{Cfg, CfgVoiceCount, 5'd1, ModeOn,  7'd0,   7'd0,   ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd60,  7'd100, ByHand, 1'b1,
      '{4'd0, 1'b1, 7'd60, 7'd100}},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd61,  7'd1,   ByHand, 1'b0, NoRes},
    // Oldest stealing: the new note takes voice 0 and no release is reported.
    '{Cfg, CfgStealPolicy, CfgW'(PolicyOldest), ModeOn, 7'd0, 7'd0, ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd62,  7'd5,   ByHand, 1'b1, '{4'd0, 1'b1, 7'd62, 7'd5}},
    '{Evt, CfgVoiceCount, 5'd0, ModeOff, 7'd60,  7'd0,   ByHand, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOff, 7'd62,  7'd33,  ByHand, 1'b1, '{4'd0, 1'b0, 7'd62, 7'd0}},
    // Three voices, then lowest stealing: below-note rule, drop when nothing is lower.
    '{Cfg, CfgVoiceCount, 5'd3, ModeOn,  7'd0,   7'd0,   ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd50,  7'd64,  ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd40,  7'd64,  ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd70,  7'd64,  ByModel, 1'b0, NoRes},
    '{Cfg, CfgStealPolicy, CfgW'(PolicyLowest), ModeOn, 7'd0, 7'd0, ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd30,  7'd7,   ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd45,  7'd9,   ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd127, 7'd127, ByModel, 1'b0, NoRes},
    // Reserved policy behaves as no stealing.
    '{Cfg, CfgStealPolicy, CfgW'(PolicyReserved), ModeOn, 7'd0, 7'd0, ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd10,  7'd10,  ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOff, 7'd70,  7'd0,   ByModel, 1'b0, NoRes},
    // No voices at all: nothing comes out.
    '{Cfg, CfgVoiceCount, 5'd0, ModeOn,  7'd0,   7'd0,   ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd5,   7'd5,   ByHand, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOff, 7'd5,   7'd0,   ByHand, 1'b0, NoRes},
    // Oversized count saturates to all voices, list restarts at voice 0.
    '{Cfg, CfgVoiceCount, 5'd31, ModeOn, 7'd0,   7'd0,   ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd64,  7'd64,  ByHand, 1'b1, '{4'd0, 1'b1, 7'd64, 7'd64}},
    // Lowest stealing tie: the oldest of two equal notes is taken; note-off hits the oldest.
    '{Cfg, CfgVoiceCount, 5'd2, ModeOn,  7'd0,   7'd0,   ByModel, 1'b0, NoRes},
    '{Cfg, CfgStealPolicy, CfgW'(PolicyLowest), ModeOn, 7'd0, 7'd0, ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd20,  7'd1,   ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd20,  7'd2,   ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOn,  7'd90,  7'd3,   ByModel, 1'b0, NoRes},
    '{Evt, CfgVoiceCount, 5'd0, ModeOff, 7'd20,  7'd0,   ByModel, 1'b0, NoRes}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic             cfg_we;
  pva_cfg_e         cfg_idx;
  logic [CfgW-1:0]  cfg_wdata;

  pva_in_if  in_ch ();
  pva_out_if out_ch ();

  poly_voice_allocator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the allocator: free list, active list (oldest first) and note per voice.
  logic [VoiceW-1:0] free_q [$];
  logic [VoiceW-1:0] active_q [$];
  logic [NoteW-1:0]  held_note [MaxVoices];
  logic [PolicyW-1:0] steal_mode;

  // Voice transactions still owed by the block, oldest first.
  gate_evt_t gate_events_q [$];

  // Hand-typed expectation for the row being driven.
  logic      by_hand;
  logic      hand_has;
  gate_evt_t hand_evt;

  // Phase with neither side idling.
  logic steady;

  int mismatches;
  int quiet_cycles;
  int rx_hold;
  logic      moved;
  logic      got;
  gate_evt_t pred;
  gate_evt_t want;

  // Rebuild the lists as a voice-count write does: free list 0..n-1, nothing active.
  function automatic void reset_voices(input logic [CfgW-1:0] count);
    int n;
    n = (count > MaxVoices) ? MaxVoices : int'(count);
    active_q.delete();
    free_q.delete();
    for (int i = 0; i < MaxVoices; i++) held_note[i] = '0;
    for (int i = 0; i < n; i++) free_q = {free_q, VoiceW'(i)};
  endfunction

  // Apply one event to the shadow lists; return 1 with the transaction if one is due.
  function automatic logic allocate_voice(input pva_mode_e mode, input logic [NoteW-1:0] note,
                                          input logic [VelW-1:0] vel, output gate_evt_t res);
    logic [VoiceW-1:0] v;
    logic [NoteW-1:0]  lowest;
    logic              found;
    int                pos;
    v = '0;
    found = 1'b0;
    pos = -1;
    res = '0;
    if (mode == ModeOn) begin
      if (free_q.size() != 0) begin
        v = free_q.pop_front();
        found = 1'b1;
      end else if (steal_mode == PolicyOldest) begin
        if (active_q.size() != 0) begin
          v = active_q[0];
          found = 1'b1;
        end
      end else if (steal_mode == PolicyLowest) begin
        // Strictly below the new note; strict compare keeps the oldest on a tie.
        lowest = note;
        foreach (active_q[i]) begin
          if (held_note[active_q[i]] < lowest) begin
            lowest = held_note[active_q[i]];
            v = active_q[i];
            found = 1'b1;
          end
        end
      end
      if (!found) return 1'b0;
      held_note[v] = note;
      // A stolen voice moves from its place in the active list to the tail.
      foreach (active_q[i]) if (active_q[i] == v) pos = i;
      if (pos >= 0) active_q.delete(pos);
      active_q = {active_q, v};
      res = '{voice: v, gate: 1'b1, note: note, vel: vel};
      return 1'b1;
    end
    foreach (active_q[i]) if (pos < 0 && held_note[active_q[i]] == note) pos = i;
    if (pos < 0) return 1'b0;
    v = active_q[pos];
    active_q.delete(pos);
    free_q = {free_q, v};
    res = '{voice: v, gate: 1'b0, note: note, vel: '0};
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input int exp_val, input int got_val);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_val, got_val, $time);
  endtask

  // Idle length: mostly none, some short, a few long; none at all in a steady phase.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Drive one event from a falling edge; return on the falling edge after acceptance.
  task automatic put_event(input pva_mode_e mode, input logic [NoteW-1:0] note,
                           input logic [VelW-1:0] vel);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.note     <= note;
    in_ch.velocity <= vel;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Write a register only once the block is idle: drain owed transactions, then let an
  // event with no result finish its walk.
  task automatic write_reg(input pva_cfg_e sel, input logic [CfgW-1:0] val);
    in_ch.valid <= 1'b0;
    while (gate_events_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= sel;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Output side: stall ready at random, hold it high in steady phases.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold == 0 && $urandom_range(0, 3) == 0) rx_hold = pick_gap();
      if (rx_hold != 0) begin
        rx_hold = rx_hold - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: apply register writes, predict on each accepted event, check each voice
  // transaction, and stop the run if the interface goes quiet for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we) begin
        moved = 1'b1;
        if (cfg_idx == CfgVoiceCount) reset_voices(cfg_wdata);
        else steal_mode = cfg_wdata[PolicyW-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        got = allocate_voice(pva_mode_e'(in_ch.mode), in_ch.note, in_ch.velocity, pred);
        if (by_hand) begin
          if (hand_has) gate_events_q = {gate_events_q, hand_evt};
        end else if (got) begin
          gate_events_q = {gate_events_q, pred};
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (gate_events_q.size() == 0) begin
          flag_mismatch("transaction with none owed, voice", -1, out_ch.voice);
        end else begin
          want = gate_events_q.pop_front();
          if (out_ch.voice !== want.voice)
            flag_mismatch("voice", want.voice, out_ch.voice);
          if (out_ch.gate !== want.gate)
            flag_mismatch("gate", want.gate, out_ch.gate);
          if (out_ch.note_out !== want.note)
            flag_mismatch("note_out", want.note, out_ch.note_out);
          if (out_ch.velocity_out !== want.vel)
            flag_mismatch("velocity_out", want.vel, out_ch.velocity_out);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t        row;
    pva_mode_e        mode;
    logic [NoteW-1:0] note;
    logic [VelW-1:0]  vel;
    logic [CfgW-1:0]  count;
    int unsigned      r;
    int               sent;
    int               burst;

    // Hold every input at a known value through reset.
    in_ch.valid    = 1'b0;
    in_ch.mode     = ModeOn;
    in_ch.note     = '0;
    in_ch.velocity = '0;
    out_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CfgVoiceCount;
    cfg_wdata      = '0;
    by_hand        = 1'b0;
    hand_has       = 1'b0;
    hand_evt       = '0;
    steady         = 1'b0;
    mismatches     = 0;
    quiet_cycles   = 0;
    rx_hold        = 0;
    steal_mode     = PolicyNone;
    reset_voices(CfgW'(VoiceCountRst));
    rst_ni         = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table: extremes, each policy and every corner named for the allocator.
    for (int k = 0; k < NumDirected; k++) begin
      row = Directed[k];
      if (row.is_cfg) begin
        write_reg(row.cfg_sel, row.cfg_val);
      end else begin
        by_hand  = row.by_hand;
        hand_has = row.has_res;
        hand_evt = row.res;
        put_event(row.mode, row.note, row.vel);
      end
    end
    by_hand = 1'b0;

    // Random phases: new settings, then a run of events shaped by the shadow state so
    // note-offs mostly hit sounding notes and the lists fill up and steal.
    sent = 0;
    while (sent < RandomItems) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       count = 5'd0;
        1:       count = 5'd1;
        2:       count = CfgW'(MaxVoices);
        3:       count = CfgW'($urandom_range(MaxVoices + 1, 31));
        default: count = CfgW'($urandom_range(2, MaxVoices - 1));
      endcase
      // Now and then keep the lists from the last phase and change only the policy.
      if (sent == 0 || $urandom_range(0, 3) != 0) write_reg(CfgVoiceCount, count);
      write_reg(CfgStealPolicy, CfgW'($urandom_range(0, 3)));
      steady = ($urandom_range(0, 4) == 0);
      burst = (free_q.size() + active_q.size() == 0) ? 12 : $urandom_range(100, 160);
      for (int k = 0; k < burst; k++) begin
        r   = $urandom_range(0, 99);
        vel = VelW'($urandom_range(0, 127));
        if (r < 8) begin
          // Noise: any mode, any note.
          mode = pva_mode_e'($urandom_range(0, 1));
          note = NoteW'($urandom_range(0, 127));
        end else if (active_q.size() != 0 && r < 48) begin
          mode = ModeOff;
          note = held_note[active_q[$urandom_range(0, active_q.size() - 1)]];
        end else begin
          // Cluster some notes so duplicates and lowest-note ties turn up.
          mode = ModeOn;
          note = ($urandom_range(0, 2) == 0) ? NoteW'($urandom_range(58, 62))
                                             : NoteW'($urandom_range(0, 127));
        end
        put_event(mode, note, vel);
        sent++;
      end
    end
    steady = 1'b0;

    // Drain: wait out every owed transaction, then the block's longest walk.
    in_ch.valid <= 1'b0;
    while (gate_events_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/pva_pkg.sv
sv/pva_in_if.sv
sv/pva_out_if.sv
sv/pva_store.sv
sv/poly_voice_allocator.sv
tb/sv/tb_top.sv
